### rtl/csup_pkg.sv
// ----------------------------------------------------------------------------
// csup_pkg: shared types and constants for per-class box suppression
// Box word layout, queue word, status word, sequencer states and defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package csup_pkg;

	localparam int MAX_BOXES_DEF   = 64;
	localparam int NUM_CLASSES_DEF = 80;
	localparam int STAT_CNT_W      = 7;
	localparam logic [15:0] IOU_RESET = 16'd29491;

	// one stored box
	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [14:0]        w;
		logic [14:0]        h;
		logic [6:0]         cls;
		logic [15:0]        score;
	} box_t;

	// one word in the front queue
	typedef struct packed {
		box_t box;
		logic store;
		logic last;
	} item_t;

	// back end status for checks
	typedef struct packed {
		logic [STAT_CNT_W-1:0] count;
	} stat_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_M,
		S_MW,
		S_N,
		S_NW,
		S_C1,
		S_C2,
		S_C3,
		S_C4,
		S_FIND,
		S_E,
		S_EW,
		S_CLR
	} state_t;

endpackage

`default_nettype wire

### rtl/csup_front.sv
// ----------------------------------------------------------------------------
// csup_front: input classification and decoupling queue
// Packs each accepted word, marks whether it is stored and whether it closes
// the frame, and holds it in a two-entry queue for the back end when it is stored or closes the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module csup_front
	import csup_pkg::*;
#(
	parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [15:0] center_x,
	input  wire logic signed [15:0] center_y,
	input  wire logic [14:0]        box_width,
	input  wire logic [14:0]        box_height,
	input  wire logic [6:0]         class_id,
	input  wire logic [15:0]        score,
	input  wire logic               last_box,
	output logic                    q_valid,
	output item_t                   q_item,
	input  wire logic               q_pop
);

	item_t       fifo_q [2];
	logic        wp_q;
	logic        rp_q;
	logic [1:0]  fcnt_q;
	item_t       item;
	logic        push;

	// classify the incoming word
	always_comb begin
		item.box.x     = center_x;
		item.box.y     = center_y;
		item.box.w     = box_width;
		item.box.h     = box_height;
		item.box.cls   = class_id;
		item.box.score = score;
		item.store     = ({1'b0, class_id} < 8'(NUM_CLASSES));
		item.last      = last_box;
	end

	assign in_stall = (fcnt_q == 2'd2);
	assign push     = in_valid && !in_stall && (item.store || item.last);
	assign q_valid  = (fcnt_q != 2'd0);
	assign q_item   = fifo_q[rp_q];

	// write queue payload
	always_ff @(posedge clk) begin
		if (push) fifo_q[wp_q] <= item;
	end

	// advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= 1'b0;
			rp_q   <= 1'b0;
			fcnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			fcnt_q <= fcnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

`default_nettype wire

### rtl/csup_back.sv
// ----------------------------------------------------------------------------
// csup_back: sorted box store, suppression pass and result emission
// Inserts boxes in key order, runs greedy overlap suppression per class when
// a frame closes, then emits survivors through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module csup_back
	import csup_pkg::*;
#(
	parameter int MAX_BOXES = MAX_BOXES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [15:0] iou_threshold,
	input  wire logic        q_valid,
	input  item_t            q_item,
	output logic             q_pop,
	output logic             out_valid,
	input  wire logic        out_stall,
	output box_t             out_box,
	output logic             out_overflow,
	output logic             out_last,
	output stat_t            stat
);

	localparam int IW = $clog2(MAX_BOXES);
	localparam int CW = $clog2(MAX_BOXES + 1);

	function automatic logic [22:0] key_of(input box_t b);
		return {b.cls, ~b.score};
	endfunction

	box_t                 mem [MAX_BOXES];
	box_t                 rd_q;
	logic                 rd_en;
	logic [IW-1:0]        rd_addr;
	logic                 wr_en;
	logic [IW-1:0]        wr_addr;
	box_t                 wr_data;

	state_t               state_q, state_d;
	logic [CW-1:0]        cnt_q, cnt_d;
	logic [CW-1:0]        i_q, i_d;
	logic [CW-1:0]        m_q, m_d;
	logic [CW-1:0]        n_q, n_d;
	logic [IW-1:0]        last_q, last_d;
	logic [MAX_BOXES-1:0] mask_q, mask_d;
	logic                 drop_q, drop_d;
	logic                 end_q, end_d;
	logic                 out_load;
	logic [CW-1:0]        im1;

	box_t                 new_q;
	box_t                 a_q;
	box_t                 b_q;

	logic signed [17:0]   l1, r1, t1, b1, l2, r2, t2, b2;
	logic signed [17:0]   lft, rgt, top, bot;
	logic signed [18:0]   iw_s1, ih_s1;
	logic [33:0]          inter_s2;
	logic [29:0]          area_a_s2, area_b_s2;
	logic                 neg_s2;
	logic [33:0]          inter_s3;
	logic [33:0]          uni_s3;
	logic                 neg_s3;
	logic [49:0]          rhs;
	logic                 hit;

	assign im1 = i_q - 1'b1;

	// store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	// overlap extents in doubled coordinates
	always_comb begin
		l1  = $signed({a_q.x[15], a_q.x, 1'b0}) - $signed({3'b0, a_q.w});
		r1  = $signed({a_q.x[15], a_q.x, 1'b0}) + $signed({3'b0, a_q.w});
		t1  = $signed({a_q.y[15], a_q.y, 1'b0}) - $signed({3'b0, a_q.h});
		b1  = $signed({a_q.y[15], a_q.y, 1'b0}) + $signed({3'b0, a_q.h});
		l2  = $signed({b_q.x[15], b_q.x, 1'b0}) - $signed({3'b0, b_q.w});
		r2  = $signed({b_q.x[15], b_q.x, 1'b0}) + $signed({3'b0, b_q.w});
		t2  = $signed({b_q.y[15], b_q.y, 1'b0}) - $signed({3'b0, b_q.h});
		b2  = $signed({b_q.y[15], b_q.y, 1'b0}) + $signed({3'b0, b_q.h});
		lft = (l1 > l2) ? l1 : l2;
		rgt = (r1 < r2) ? r1 : r2;
		top = (t1 > t2) ? t1 : t2;
		bot = (b1 < b2) ? b1 : b2;
	end

	// threshold test against the union
	assign rhs = 50'(iou_threshold) * 50'(uni_s3);
	assign hit = !neg_s3 && (uni_s3 != '0) && ({inter_s3, 16'b0} > rhs);

	// overlap datapath stages
	always_ff @(posedge clk) begin
		if (state_q == S_C1) begin
			iw_s1 <= {rgt[17], rgt} - {lft[17], lft};
			ih_s1 <= {bot[17], bot} - {top[17], top};
		end
		if (state_q == S_C2) begin
			inter_s2  <= 34'(iw_s1[16:0]) * 34'(ih_s1[16:0]);
			area_a_s2 <= 30'(a_q.w) * 30'(a_q.h);
			area_b_s2 <= 30'(b_q.w) * 30'(b_q.h);
			neg_s2    <= iw_s1[18] || ih_s1[18];
		end
		if (state_q == S_C3) begin
			inter_s3 <= inter_s2;
			uni_s3   <= {2'b0, area_a_s2, 2'b0} + {2'b0, area_b_s2, 2'b0} - inter_s2;
			neg_s3   <= neg_s2;
		end
	end

	// hold operand boxes
	always_ff @(posedge clk) begin
		if (q_pop) new_q <= q_item.box;
		if (state_q == S_MW) a_q <= rd_q;
		if (state_q == S_NW) b_q <= rd_q;
	end

	// sequencer: next state and store control
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		i_d      = i_q;
		m_d      = m_q;
		n_d      = n_q;
		last_d   = last_q;
		mask_d   = mask_q;
		drop_d   = drop_q;
		end_d    = end_q;
		rd_en    = 1'b0;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = '0;
		wr_data  = new_q;
		q_pop    = 1'b0;
		out_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					end_d = q_item.last;
					m_d   = '0;
					if (q_item.store && cnt_q == CW'(MAX_BOXES)) begin
						drop_d  = 1'b1;
						state_d = q_item.last ? S_M : S_IDLE;
					end else if (q_item.store && cnt_q == '0) begin
						wr_en   = 1'b1;
						wr_data = q_item.box;
						cnt_d   = cnt_q + 1'b1;
						state_d = q_item.last ? S_M : S_IDLE;
					end else if (q_item.store) begin
						i_d     = cnt_q;
						state_d = S_INS_RD;
					end else begin
						state_d = q_item.last ? S_M : S_IDLE;
					end
				end
			end
			S_INS_RD: begin
				if (i_q == '0) begin
					wr_en   = 1'b1;
					cnt_d   = cnt_q + 1'b1;
					state_d = end_q ? S_M : S_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = im1[IW-1:0];
					state_d = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				wr_en   = 1'b1;
				wr_addr = i_q[IW-1:0];
				if (key_of(rd_q) > key_of(new_q)) begin
					wr_data = rd_q;
					i_d     = im1;
					state_d = S_INS_RD;
				end else begin
					cnt_d   = cnt_q + 1'b1;
					state_d = end_q ? S_M : S_IDLE;
				end
			end
			S_M: begin
				if (m_q >= cnt_q) begin
					n_d     = cnt_q - 1'b1;
					state_d = (cnt_q == '0) ? S_CLR : S_FIND;
				end else if (mask_q[m_q[IW-1:0]]) begin
					m_d = m_q + 1'b1;
				end else begin
					rd_en   = 1'b1;
					rd_addr = m_q[IW-1:0];
					state_d = S_MW;
				end
			end
			S_MW: begin
				n_d     = m_q + 1'b1;
				state_d = S_N;
			end
			S_N: begin
				if (n_q >= cnt_q) begin
					m_d     = m_q + 1'b1;
					state_d = S_M;
				end else begin
					rd_en   = 1'b1;
					rd_addr = n_q[IW-1:0];
					state_d = S_NW;
				end
			end
			S_NW: begin
				if (rd_q.cls != a_q.cls) begin
					m_d     = m_q + 1'b1;
					state_d = S_M;
				end else if (mask_q[n_q[IW-1:0]]) begin
					n_d     = n_q + 1'b1;
					state_d = S_N;
				end else begin
					state_d = S_C1;
				end
			end
			S_C1: state_d = S_C2;
			S_C2: state_d = S_C3;
			S_C3: state_d = S_C4;
			S_C4: begin
				if (hit) mask_d[n_q[IW-1:0]] = 1'b1;
				n_d     = n_q + 1'b1;
				state_d = S_N;
			end
			S_FIND: begin
				if (!mask_q[n_q[IW-1:0]]) begin
					last_d  = n_q[IW-1:0];
					m_d     = '0;
					state_d = S_E;
				end else begin
					n_d = n_q - 1'b1;
				end
			end
			S_E: begin
				if (m_q >= cnt_q) begin
					state_d = S_CLR;
				end else if (mask_q[m_q[IW-1:0]]) begin
					m_d = m_q + 1'b1;
				end else begin
					rd_en   = 1'b1;
					rd_addr = m_q[IW-1:0];
					state_d = S_EW;
				end
			end
			S_EW: begin
				if (!out_valid || !out_stall) begin
					out_load = 1'b1;
					m_d      = m_q + 1'b1;
					state_d  = S_E;
				end
			end
			S_CLR: begin
				cnt_d   = '0;
				mask_d  = '0;
				drop_d  = 1'b0;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			i_q     <= '0;
			m_q     <= '0;
			n_q     <= '0;
			last_q  <= '0;
			mask_q  <= '0;
			drop_q  <= 1'b0;
			end_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			i_q     <= i_d;
			m_q     <= m_d;
			n_q     <= n_d;
			last_q  <= last_d;
			mask_q  <= mask_d;
			drop_q  <= drop_d;
			end_q   <= end_d;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_box      <= rd_q;
			out_overflow <= drop_q;
			out_last     <= (m_q[IW-1:0] == last_q);
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	assign stat.count = STAT_CNT_W'(cnt_q);

endmodule

`default_nettype wire

### rtl/classwise_box_suppression.sv
// ----------------------------------------------------------------------------
// classwise_box_suppression: per-class greedy overlap suppression
// Collects a frame of boxes in class/score order and emits the survivors.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  in       | input     | in_valid / in_stall   | center_x .. last_box
//  out      | output    | out_valid / out_stall | kept_x .. last_result
//  cfg      | input     | cfg_wr_en             | cfg_wr_data (iou_threshold)
//
//  Loading a box writes it straight into an empty store; otherwise it reads and
//  moves each stored entry with a larger key up one place until it lands.
//  Suppression compares each kept reference box with later boxes of its class,
//  each pair through one store read and the overlap datapath states S_C1 to S_C4,
//  skipping removed boxes; emission then reads and outputs each surviving box.
//  Reset clears counts, mask and flags; store contents are left as they are.
//  A stalled output holds the back end; the front queue takes words until both of
//  its entries are full.
// ----------------------------------------------------------------------------
`default_nettype none

module classwise_box_suppression
	import csup_pkg::*;
#(
	parameter int MAX_BOXES   = MAX_BOXES_DEF,
	parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [15:0]        cfg_wr_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [15:0] center_x,
	input  wire logic signed [15:0] center_y,
	input  wire logic [14:0]        box_width,
	input  wire logic [14:0]        box_height,
	input  wire logic [6:0]         class_id,
	input  wire logic [15:0]        score,
	input  wire logic               last_box,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      kept_x,
	output logic signed [15:0]      kept_y,
	output logic [14:0]             kept_width,
	output logic [14:0]             kept_height,
	output logic [6:0]              kept_class,
	output logic [15:0]             kept_score,
	output logic                    overflow,
	output logic                    last_result
);

	logic [15:0] iou_q;
	logic        q_valid;
	item_t       q_item;
	logic        q_pop;
	box_t        out_box;
	stat_t       stat;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iou_q <= IOU_RESET;
		end else if (cfg_wr_en) begin
			iou_q <= cfg_wr_data;
		end
	end

	csup_front #(
		.NUM_CLASSES(NUM_CLASSES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.center_x   (center_x),
		.center_y   (center_y),
		.box_width  (box_width),
		.box_height (box_height),
		.class_id   (class_id),
		.score      (score),
		.last_box   (last_box),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop)
	);

	csup_back #(
		.MAX_BOXES(MAX_BOXES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.iou_threshold (iou_q),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_box       (out_box),
		.out_overflow  (overflow),
		.out_last      (last_result),
		.stat          (stat)
	);

	assign kept_x      = out_box.x;
	assign kept_y      = out_box.y;
	assign kept_width  = out_box.w;
	assign kept_height = out_box.h;
	assign kept_class  = out_box.cls;
	assign kept_score  = out_box.score;

`ifndef NO_ASSERTIONS
	// store fill never passes capacity
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= STAT_CNT_W'(MAX_BOXES))
		else $error("store count beyond capacity");

	// fill grows by one box at a time or empties at frame end
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count != $past(stat.count) |->
			(stat.count == $past(stat.count) + 7'd1) || (stat.count == '0))
		else $error("store count jumped");

	// a popped queue word needs a queued word
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: per-class box suppression check
// Drives frames of boxes through the block with random idling on both sides,
// predicts the surviving boxes per frame and compares every output word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
	import csup_pkg::*;
();

	localparam int CAP = MAX_BOXES_DEF;
	localparam int NCLS = NUM_CLASSES_DEF;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [14:0] w;
		logic [14:0] h;
		logic [6:0] cls;
		logic [15:0] score;
		logic last;
	} det_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [14:0] w;
		logic [14:0] h;
		logic [6:0] cls;
		logic [15:0] score;
		logic ovf;
		logic last;
	} kept_t;

	typedef struct {
		det_t d;
		logic chk;
		kept_t k;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] center_x = '0;
	logic signed [15:0] center_y = '0;
	logic [14:0] box_width = '0;
	logic [14:0] box_height = '0;
	logic [6:0] class_id = '0;
	logic [15:0] score = '0;
	logic last_box = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] kept_x;
	logic signed [15:0] kept_y;
	logic [14:0] kept_width;
	logic [14:0] kept_height;
	logic [6:0] kept_class;
	logic [15:0] kept_score;
	logic overflow;
	logic last_result;

	// predictor state
	det_t frame_boxes[$];
	logic dropped;
	logic [15:0] iou_thr = IOU_RESET;
	kept_t survivors[$];
	int errors = 0;
	longint cycles = 0;
	logic quiet = 1'b0;
	logic stall_on = 1'b1;
	int stall_left = 0;

	classwise_box_suppression u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.center_x(center_x), .center_y(center_y),
		.box_width(box_width), .box_height(box_height),
		.class_id(class_id), .score(score), .last_box(last_box),
		.out_valid(out_valid), .out_stall(out_stall),
		.kept_x(kept_x), .kept_y(kept_y),
		.kept_width(kept_width), .kept_height(kept_height),
		.kept_class(kept_class), .kept_score(kept_score),
		.overflow(overflow), .last_result(last_result)
	);

	always #6 clk = ~clk;

	// overlap test on doubled coordinates, no division
	function automatic logic too_close(det_t a, det_t b, logic [15:0] thr);
		longint l1, r1, t1, b1, l2, r2, t2, b2, lf, rt, tp, bt;
		longint unsigned inter, uni;
		l1 = 2 * longint'(a.x) - a.w; r1 = 2 * longint'(a.x) + a.w;
		t1 = 2 * longint'(a.y) - a.h; b1 = 2 * longint'(a.y) + a.h;
		l2 = 2 * longint'(b.x) - b.w; r2 = 2 * longint'(b.x) + b.w;
		t2 = 2 * longint'(b.y) - b.h; b2 = 2 * longint'(b.y) + b.h;
		lf = l1 > l2 ? l1 : l2;
		rt = r1 < r2 ? r1 : r2;
		tp = t1 > t2 ? t1 : t2;
		bt = b1 < b2 ? b1 : b2;
		if (tp > bt || lf > rt)
			return 1'b0;
		inter = longint'(rt - lf) * longint'(bt - tp);
		uni = 4 * longint'(a.w) * a.h + 4 * longint'(b.w) * b.h - inter;
		if (uni == 0)
			return 1'b0;
		return (inter << 16) > longint'(thr) * uni;
	endfunction

	// accept one box: sorted insert, and on the frame end queue survivors
	task automatic predict_box(det_t d);
		int pos;
		logic [63:0] gone;
		kept_t k;
		int lastk;
		pos = 0;
		if (d.cls < NCLS) begin
			if (frame_boxes.size() >= CAP) begin
				dropped = 1'b1;
			end else begin
				while (pos < frame_boxes.size() &&
					(frame_boxes[pos].cls < d.cls ||
					(frame_boxes[pos].cls == d.cls && frame_boxes[pos].score >= d.score)))
					pos++;
				frame_boxes.insert(pos, d);
			end
		end
		if (!d.last)
			return;
		gone = '0;
		for (int m = 0; m < frame_boxes.size(); m++) begin
			if (gone[m])
				continue;
			for (int n = m + 1; n < frame_boxes.size(); n++) begin
				if (frame_boxes[n].cls != frame_boxes[m].cls)
					break;
				if (!gone[n] && too_close(frame_boxes[m], frame_boxes[n], iou_thr))
					gone[n] = 1'b1;
			end
		end
		lastk = -1;
		for (int m = 0; m < frame_boxes.size(); m++) begin
			if (gone[m])
				continue;
			k = '{frame_boxes[m].x, frame_boxes[m].y, frame_boxes[m].w, frame_boxes[m].h,
				frame_boxes[m].cls, frame_boxes[m].score, dropped, 1'b0};
			survivors.insert(survivors.size(), k);
			lastk = survivors.size() - 1;
		end
		if (lastk >= 0)
			survivors[lastk].last = 1'b1;
		frame_boxes.delete();
		dropped = 1'b0;
	endtask

	// hold one word on the input until it is taken; valid stays up afterwards
	task automatic send_box(det_t d);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		center_x <= d.x; center_y <= d.y; box_width <= d.w; box_height <= d.h;
		class_id <= d.cls; score <= d.score; last_box <= d.last;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_box(d);
		@(negedge clk);
	endtask

	// drop valid and wait for every expected word
	task automatic drain;
		in_valid <= 1'b0;
		while (survivors.size() > 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic write_thr(logic [15:0] v);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		iou_thr = v;
	endtask

	function automatic det_t rand_box(int ncls, logic last);
		det_t d;
		d.x = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 4095));
		d.y = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 4095));
		d.w = $urandom_range(0, 1) ? 15'($urandom) : 15'($urandom_range(0, 2047));
		d.h = $urandom_range(0, 1) ? 15'($urandom) : 15'($urandom_range(0, 2047));
		d.cls = $urandom_range(0, 15) == 0 ? 7'($urandom) : 7'($urandom_range(0, ncls));
		d.score = 16'($urandom);
		d.last = last;
		return d;
	endfunction

	// check every output word against the oldest survivor
	always @(posedge clk) begin
		kept_t exp;
		cycles++;
		if (arst_n && out_valid && !out_stall) begin
			if (survivors.size() == 0) begin
				$error("unexpected output word x=%0d cls=%0d", kept_x, kept_class);
				errors++;
			end else begin
				exp = survivors.pop_front();
				if (kept_x !== exp.x) begin
					$error("kept_x exp %0d got %0d", exp.x, kept_x); errors++;
				end
				if (kept_y !== exp.y) begin
					$error("kept_y exp %0d got %0d", exp.y, kept_y); errors++;
				end
				if (kept_width !== exp.w) begin
					$error("kept_width exp %0d got %0d", exp.w, kept_width); errors++;
				end
				if (kept_height !== exp.h) begin
					$error("kept_height exp %0d got %0d", exp.h, kept_height); errors++;
				end
				if (kept_class !== exp.cls) begin
					$error("kept_class exp %0d got %0d", exp.cls, kept_class); errors++;
				end
				if (kept_score !== exp.score) begin
					$error("kept_score exp %0d got %0d", exp.score, kept_score); errors++;
				end
				if (overflow !== exp.ovf) begin
					$error("overflow exp %0d got %0d", exp.ovf, overflow); errors++;
				end
				if (last_result !== exp.last) begin
					$error("last_result exp %0d got %0d", exp.last, last_result); errors++;
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// output stall in random bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (!quiet && stall_on && $urandom_range(0, 4) == 0) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 3);
		end else begin
			out_stall <= 1'b0;
		end
	end

	initial begin
		row_t rows[$];
		row_t r;
		det_t d;
		int nfr;
		int got;
		dropped = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// directed table; chk rows carry a survivor read off directly
		r.chk = 1'b0; r.k = '0;
		r.d = '{16'sh7FFF, -16'sd32768, 15'h7FFF, 15'h0, 7'd0, 16'hFFFF, 1'b1};
		r.chk = 1'b1;
		r.k = '{16'sh7FFF, -16'sd32768, 15'h7FFF, 15'h0, 7'd0, 16'hFFFF, 1'b0, 1'b1};
		rows.insert(rows.size(), r);
		r.chk = 1'b1;
		r.d = '{-16'sd32768, 16'sh7FFF, 15'h0, 15'h7FFF, 7'd79, 16'h0, 1'b1};
		r.k = '{-16'sd32768, 16'sh7FFF, 15'h0, 15'h7FFF, 7'd79, 16'h0, 1'b0, 1'b1};
		rows.insert(rows.size(), r);
		r.chk = 1'b0;
		// out of range class only: empty frame
		r.d = '{16'sd0, 16'sd0, 15'd100, 15'd100, 7'd127, 16'd5, 1'b1};
		rows.insert(rows.size(), r);
		r.d = '{16'sd0, 16'sd0, 15'd0, 15'd0, 7'd80, 16'd5, 1'b1};
		rows.insert(rows.size(), r);
		// identical boxes, equal scores, zero-area pair, disjoint pair
		r.d = '{16'sd100, 16'sd100, 15'd400, 15'd400, 7'd3, 16'd500, 1'b0};
		rows.insert(rows.size(), r);
		r.d = '{16'sd100, 16'sd100, 15'd400, 15'd400, 7'd3, 16'd500, 1'b0};
		rows.insert(rows.size(), r);
		r.d = '{16'sd110, 16'sd90, 15'd400, 15'd400, 7'd3, 16'd900, 1'b0};
		rows.insert(rows.size(), r);
		r.d = '{16'sd5000, 16'sd100, 15'd400, 15'd400, 7'd3, 16'd100, 1'b0};
		rows.insert(rows.size(), r);
		r.d = '{16'sd0, 16'sd0, 15'd0, 15'd0, 7'd2, 16'd7, 1'b0};
		rows.insert(rows.size(), r);
		r.d = '{16'sd0, 16'sd0, 15'd0, 15'd0, 7'd2, 16'd6, 1'b0};
		rows.insert(rows.size(), r);
		r.d = '{16'sd100, 16'sd100, 15'd400, 15'd400, 7'd4, 16'd500, 1'b0};
		rows.insert(rows.size(), r);
		r.d = '{16'sd300, 16'sd100, 15'd400, 15'd400, 7'd3, 16'hFFFF, 1'b1};
		rows.insert(rows.size(), r);
		foreach (rows[i]) begin
			if (rows[i].chk) begin
				drain();
				send_box(rows[i].d);
				got = survivors.size();
				if (got != 1) begin
					$error("directed row %0d: survivor count exp 1 got %0d", i, got);
					errors++;
				end else if (survivors[0] !== rows[i].k) begin
					$error("directed row %0d: survivor exp %h got %h",
						i, rows[i].k, survivors[0]);
					errors++;
				end
			end else begin
				send_box(rows[i].d);
			end
		end

		// overflow frame: capacity plus three boxes, last one dropped too
		for (int i = 0; i <= CAP + 2; i++) begin
			d = rand_box(7, i == CAP + 2);
			d.cls = 7'($urandom_range(0, 6));
			send_box(d);
		end

		// random frames across thresholds, extremes included
		nfr = 0;
		while (nfr < 45) begin
			case (nfr)
				0: write_thr(16'd0);
				10: write_thr(16'hFFFF);
				20: write_thr(16'($urandom));
				30: write_thr(16'd16384);
				35: quiet = 1'b1;
				default: ;
			endcase
			if (nfr == 15) begin
				// let every survivor out before the next frame
				drain();
			end
			got = $urandom_range(1, 9);
			for (int i = 0; i < got; i++) begin
				d = rand_box($urandom_range(0, 1) ? 2 : 79, i == got - 1);
				if ($urandom_range(0, 7) == 0)
					d.last = 1'b1;
				send_box(d);
			end
			nfr++;
		end
		write_thr(IOU_RESET);
		for (int i = 0; i < 6; i++) begin
			d = rand_box(1, i == 5);
			send_box(d);
		end

		drain();
		if (errors == 0 && survivors.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

### files.f
rtl/csup_pkg.sv
rtl/csup_front.sv
rtl/csup_back.sv
rtl/classwise_box_suppression.sv
test/testbench.sv
